### hw/rtl/label_connectivity_enforcer_defines.svh
// Assertion macros used by the checker of the label connectivity enforcer.
`ifndef LABEL_CONNECTIVITY_ENFORCER_DEFINES_SVH
`define LABEL_CONNECTIVITY_ENFORCER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define LCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define LCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lce_pkg.sv
// Shared types and constants of the label connectivity enforcer.
package lce_pkg;

    localparam int DIM_W   = 9;   // image width and height
    localparam int COORD_W = 8;   // x or y coordinate inside the image
    localparam int PIX_W   = 17;  // pixel count and raster index
    localparam int SEG_W   = 17;  // segment counter and target
    localparam int OLAB_W  = 16;  // new label width
    localparam int ILAB_W  = 16;  // label_in field width
    localparam int IDX_W   = 16;  // pixel_index field width

    localparam logic [DIM_W-1:0] DIM_MAX   = 9'd256;
    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
    localparam logic [SEG_W-1:0] TGT_RESET = 17'd256;

    // Item kinds carried on tuser.
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // Kind code that no item type uses; it always answers with error status.
    localparam logic [1:0] KIND_BAD = 2'd3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_TARGET = 2'd2
    } cfg_idx_t;

    // Neighbor directions in visiting order.
    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    // Fill queue entry: pixel coordinates.
    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } coord_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_DIV,
        ST_CLR,
        ST_SCAN,
        ST_SCAN_W,
        ST_ADJ,
        ST_ADJ_W,
        ST_NB,
        ST_NB_W,
        ST_POP,
        ST_POP_W,
        ST_FIN,
        ST_RELAB,
        ST_RELAB_W,
        ST_ADV
    } state_t;

endpackage

### hw/rtl/label_connectivity_enforcer.sv
// Top level of the label connectivity enforcer: sequencer around the label memories.
//
//  Channel  Direction  Handshake          Content
//  s_*      in         tvalid/tready      write, run or read item
//  m_*      out        tvalid/tready      new label, segment count, status
//  cfg_*    in         cfg_we             width, height, target writes
//
// A write item is answered from the idle state; a read item passes through
// ST_RD_WAIT for the registered memory read. A run item goes through the size
// limit division, a clearing pass over the visited marks and a scan of every
// pixel. Each new segment adds an adjacency check of its neighbors, a neighbor
// test for every filled pixel, the queue pops and, when it is small, a
// relabeling pass over its pixels; the shared memory ports set these steps.
// Reset clears the control state; the label stores are undefined until written.
// A result waits in the output register; no item is taken while it stalls.
module label_connectivity_enforcer #(
    parameter int MAX_PIXELS = 65536,
    parameter int LABEL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_index[15:0], label_in[31:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // new_label[15:0], segment_count[32:16], status[33]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    import lce_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PIXELS);

    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     width_reg, height_reg;
    logic [SEG_W-1:0]     target_reg;
    logic [PIX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [COORD_W-1:0]   scan_x_reg, scan_x_next, scan_y_reg, scan_y_next;
    logic [PIX_W-1:0]     cur_i_reg, cur_i_next;
    logic [COORD_W-1:0]   cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [1:0]           dir_reg, dir_next;
    logic [PIX_W-1:0]     head_reg, head_next, count_reg, count_next;
    logic [LABEL_BITS-1:0] seed_lab_reg, seed_lab_next;
    logic [PIX_W-1:0]     nb_i_reg, nb_i_next;
    logic [COORD_W-1:0]   nb_x_reg, nb_x_next, nb_y_reg, nb_y_next;
    logic [SEG_W-1:0]     next_label_reg, next_label_next;
    logic [OLAB_W-1:0]    adj_label_reg, adj_label_next;
    logic [SEG_W-1:0]     last_seg_reg, last_seg_next;
    logic [SEG_W-1:0]     limit_reg, limit_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OLAB_W-1:0]    out_label_reg, out_label_next;
    logic                 out_status_reg, out_status_next;

    // Derived image size and item fields.
    logic [2*DIM_W-1:0]   pixels;
    logic [PIX_W-1:0]     pix17;
    logic                 size_ok, idx_ok, out_free, accept;
    logic [IDX_W-1:0]     pidx;
    logic [ILAB_W-1:0]    lab;

    // Neighbor of the current pixel.
    logic                 nb_ok;
    logic [PIX_W-1:0]     nb_i;
    logic [COORD_W-1:0]   nb_x, nb_y;
    logic [PIX_W-1:0]     cnt_tmp;

    // Memory ports.
    logic                 vis_we, vis_wdata, vis_rdata;
    logic [ADDR_W-1:0]    vis_waddr, vis_raddr;
    logic                 in_we;
    logic [ADDR_W-1:0]    in_waddr, in_raddr;
    logic [LABEL_BITS-1:0] in_wdata, in_rdata;
    logic                 out_we;
    logic [ADDR_W-1:0]    out_waddr, out_raddr;
    logic [OLAB_W-1:0]    out_wdata, out_rdata;
    logic                 q_we;
    logic [ADDR_W-1:0]    q_waddr, q_raddr;
    coord_t               q_wdata, q_rdata;

    // Divider for the small segment limit.
    logic                 div_start, div_done;
    logic [SEG_W-1:0]     div_quo;

    lce_ram #(.WIDTH(1), .DEPTH(MAX_PIXELS)) u_visited (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    lce_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_PIXELS)) u_in_labels (
        .clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
        .raddr(in_raddr), .rdata(in_rdata)
    );

    lce_ram #(.WIDTH(OLAB_W), .DEPTH(MAX_PIXELS)) u_out_labels (
        .clk(clk), .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
        .raddr(out_raddr), .rdata(out_rdata)
    );

    lce_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_PIXELS)) u_fill_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    lce_div #(.W(SEG_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(pix17), .divisor(target_reg),
        .done(div_done), .quotient(div_quo)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            target_reg <= TGT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_TARGET: target_reg <= cfg_data[SEG_W-1:0];
                default:    ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            next_label_reg <= '0;
            adj_label_reg  <= '0;
            last_seg_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            next_label_reg <= next_label_next;
            adj_label_reg  <= adj_label_next;
            last_seg_reg   <= last_seg_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        scan_x_reg     <= scan_x_next;
        scan_y_reg     <= scan_y_next;
        cur_i_reg      <= cur_i_next;
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        dir_reg        <= dir_next;
        head_reg       <= head_next;
        count_reg      <= count_next;
        seed_lab_reg   <= seed_lab_next;
        nb_i_reg       <= nb_i_next;
        nb_x_reg       <= nb_x_next;
        nb_y_reg       <= nb_y_next;
        limit_reg      <= limit_next;
        out_label_reg  <= out_label_next;
        out_status_reg <= out_status_next;
    end

    // Image size checks.
    always_comb
    begin
        pixels  = width_reg * height_reg;
        pix17   = pixels[PIX_W-1:0];
        size_ok = (width_reg != '0) && (width_reg <= DIM_MAX) &&
                  (height_reg != '0) && (height_reg <= DIM_MAX) &&
                  (32'(pixels) <= 32'(MAX_PIXELS));
        pidx    = s_tdata[IDX_W-1:0];
        lab     = s_tdata[IDX_W +: ILAB_W];
        idx_ok  = ({1'b0, pidx} < pix17);
    end

    // Neighbor position and bounds for the current pixel and direction.
    always_comb
    begin
        nb_ok = 1'b0;
        nb_i  = cur_i_reg;
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        unique case (dir_t'(dir_reg))
            DIR_LEFT:
            begin
                nb_ok = (cur_x_reg != '0);
                nb_i  = cur_i_reg - PIX_W'(1);
                nb_x  = cur_x_reg - COORD_W'(1);
            end
            DIR_UP:
            begin
                nb_ok = (cur_y_reg != '0);
                nb_i  = cur_i_reg - PIX_W'(width_reg);
                nb_y  = cur_y_reg - COORD_W'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok = (({1'b0, cur_x_reg} + DIM_W'(1)) < width_reg);
                nb_i  = cur_i_reg + PIX_W'(1);
                nb_x  = cur_x_reg + COORD_W'(1);
            end
            DIR_DOWN:
            begin
                nb_ok = (({1'b0, cur_y_reg} + DIM_W'(1)) < height_reg);
                nb_i  = cur_i_reg + PIX_W'(width_reg);
                nb_y  = cur_y_reg + COORD_W'(1);
            end
            default: ;
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Sequencer: next state, memory accesses and result loading.
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        scan_x_next     = scan_x_reg;
        scan_y_next     = scan_y_reg;
        cur_i_next      = cur_i_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        dir_next        = dir_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        seed_lab_next   = seed_lab_reg;
        nb_i_next       = nb_i_reg;
        nb_x_next       = nb_x_reg;
        nb_y_next       = nb_y_reg;
        next_label_next = next_label_reg;
        adj_label_next  = adj_label_reg;
        last_seg_next   = last_seg_reg;
        limit_next      = limit_reg;
        out_valid_next  = out_valid_reg;
        out_label_next  = out_label_reg;
        out_status_next = out_status_reg;
        cnt_tmp         = count_reg;

        vis_we    = 1'b0;
        vis_waddr = ADDR_W'(scan_idx_reg);
        vis_wdata = 1'b0;
        vis_raddr = ADDR_W'(scan_idx_reg);
        in_we     = 1'b0;
        in_waddr  = ADDR_W'(pidx);
        in_wdata  = LABEL_BITS'(lab);
        in_raddr  = ADDR_W'(scan_idx_reg);
        out_we    = 1'b0;
        out_waddr = ADDR_W'(scan_idx_reg);
        out_wdata = next_label_reg[OLAB_W-1:0];
        out_raddr = ADDR_W'(pidx);
        q_we      = 1'b0;
        q_waddr   = ADDR_W'(count_reg);
        q_wdata   = '{y: nb_y_reg, x: nb_x_reg};
        q_raddr   = ADDR_W'(head_reg);
        div_start = 1'b0;

        // A waiting result leaves when taken.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_label_next  = '0;
                    out_status_next = 1'b1;
                    out_valid_next  = 1'b1;
                    unique case (kind_t'(s_tuser))
                        KIND_WRITE:
                        begin
                            if (size_ok && idx_ok)
                            begin
                                in_we           = 1'b1;
                                out_status_next = 1'b0;
                            end
                        end
                        KIND_RUN:
                        begin
                            if (size_ok && (target_reg != '0))
                            begin
                                out_valid_next  = 1'b0;
                                div_start       = 1'b1;
                                next_label_next = '0;
                                adj_label_next  = '0;
                                state_next      = ST_DIV;
                            end
                        end
                        KIND_READ:
                        begin
                            if (size_ok && idx_ok)
                            begin
                                out_valid_next = 1'b0;
                                state_next     = ST_RD_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                out_valid_next  = 1'b1;
                out_label_next  = out_rdata;
                out_status_next = 1'b0;
                state_next      = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    limit_next    = div_quo >> 2;
                    scan_idx_next = '0;
                    state_next    = ST_CLR;
                end
            end
            ST_CLR:
            begin
                vis_we = 1'b1;
                if (scan_idx_reg + PIX_W'(1) == pix17)
                begin
                    scan_idx_next = '0;
                    scan_x_next   = '0;
                    scan_y_next   = '0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + PIX_W'(1);
                end
            end
            ST_SCAN:
            begin
                state_next = ST_SCAN_W;
            end
            ST_SCAN_W:
            begin
                if (vis_rdata)
                begin
                    state_next = ST_ADV;
                end
                else
                begin
                    // Open a new segment at this pixel.
                    seed_lab_next = in_rdata;
                    vis_we        = 1'b1;
                    vis_wdata     = 1'b1;
                    out_we        = 1'b1;
                    q_we          = 1'b1;
                    q_waddr       = '0;
                    q_wdata       = '{y: scan_y_reg, x: scan_x_reg};
                    count_next    = PIX_W'(1);
                    head_next     = '0;
                    cur_i_next    = scan_idx_reg;
                    cur_x_next    = scan_x_reg;
                    cur_y_next    = scan_y_reg;
                    dir_next      = DIR_LEFT;
                    state_next    = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                vis_raddr = ADDR_W'(nb_i);
                out_raddr = ADDR_W'(nb_i);
                if (nb_ok)
                begin
                    state_next = ST_ADJ_W;
                end
                else if (dir_reg == DIR_DOWN)
                begin
                    dir_next   = DIR_LEFT;
                    state_next = ST_NB;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            ST_ADJ_W:
            begin
                if (vis_rdata)
                begin
                    adj_label_next = out_rdata;
                end
                if (dir_reg == DIR_DOWN)
                begin
                    dir_next   = DIR_LEFT;
                    state_next = ST_NB;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_ADJ;
                end
            end
            ST_NB, ST_NB_W:
            begin
                vis_raddr = ADDR_W'(nb_i);
                in_raddr  = ADDR_W'(nb_i);
                if ((state_reg == ST_NB) && nb_ok)
                begin
                    nb_i_next  = nb_i;
                    nb_x_next  = nb_x;
                    nb_y_next  = nb_y;
                    state_next = ST_NB_W;
                end
                else
                begin
                    // Grow the segment over a matching unvisited neighbor.
                    if ((state_reg == ST_NB_W) && !vis_rdata && (in_rdata == seed_lab_reg))
                    begin
                        vis_we     = 1'b1;
                        vis_waddr  = ADDR_W'(nb_i_reg);
                        vis_wdata  = 1'b1;
                        out_we     = 1'b1;
                        out_waddr  = ADDR_W'(nb_i_reg);
                        q_we       = 1'b1;
                        cnt_tmp    = count_reg + PIX_W'(1);
                        count_next = cnt_tmp;
                    end
                    if (dir_reg != DIR_DOWN)
                    begin
                        dir_next   = dir_reg + 2'd1;
                        state_next = ST_NB;
                    end
                    else
                    begin
                        dir_next  = DIR_LEFT;
                        head_next = head_reg + PIX_W'(1);
                        if (head_reg + PIX_W'(1) == cnt_tmp)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_POP;
                        end
                    end
                end
            end
            ST_POP:
            begin
                state_next = ST_POP_W;
            end
            ST_POP_W:
            begin
                cur_x_next = q_rdata.x;
                cur_y_next = q_rdata.y;
                cur_i_next = (PIX_W'(q_rdata.y) * PIX_W'(width_reg)) + PIX_W'(q_rdata.x);
                state_next = ST_NB;
            end
            ST_FIN:
            begin
                if (count_reg <= limit_reg)
                begin
                    head_next  = '0;
                    state_next = ST_RELAB;
                end
                else
                begin
                    next_label_next = next_label_reg + SEG_W'(1);
                    state_next      = ST_ADV;
                end
            end
            ST_RELAB:
            begin
                state_next = ST_RELAB_W;
            end
            ST_RELAB_W:
            begin
                // Small segment takes the adjacent label.
                out_we    = 1'b1;
                out_waddr = ADDR_W'((PIX_W'(q_rdata.y) * PIX_W'(width_reg)) +
                                    PIX_W'(q_rdata.x));
                out_wdata = adj_label_reg;
                head_next = head_reg + PIX_W'(1);
                if (head_reg + PIX_W'(1) == count_reg)
                begin
                    state_next = ST_ADV;
                end
                else
                begin
                    state_next = ST_RELAB;
                end
            end
            ST_ADV:
            begin
                if (scan_idx_reg + PIX_W'(1) == pix17)
                begin
                    last_seg_next   = next_label_reg;
                    out_valid_next  = 1'b1;
                    out_label_next  = '0;
                    out_status_next = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + PIX_W'(1);
                    if ({1'b0, scan_x_reg} + DIM_W'(1) == width_reg)
                    begin
                        scan_x_next = '0;
                        scan_y_next = scan_y_reg + COORD_W'(1);
                    end
                    else
                    begin
                        scan_x_next = scan_x_reg + COORD_W'(1);
                    end
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_status_reg, last_seg_reg, out_label_reg};

endmodule

### hw/rtl/lce_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module lce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/lce_div.sv
// Restoring divider, one quotient bit per cycle.
module lce_div #(
    parameter int W = 17
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     div_reg, div_next;
    logic [W:0]       shifted;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    // One shift and conditional subtract per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = shifted - {1'b0, div_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/lce_checker.sv
// Port-level assertions of the label connectivity enforcer and their bind.
`include "label_connectivity_enforcer_defines.svh"

module lce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    import lce_pkg::*;

    // A stalled result holds.
    `LCE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // No new item while the result register is blocked.
    `LCE_ASSERT_NOW(a_no_accept_blocked, m_tvalid && !m_tready, !s_tready, "item taken while output blocked")

    // A write transaction answers in the next cycle.
    `LCE_ASSERT_NEXT(a_write_answer, s_tvalid && s_tready && (s_tuser == KIND_WRITE), m_tvalid, "write gave no result")

    // An unknown kind answers with error status.
    `LCE_ASSERT_NEXT(a_bad_kind, s_tvalid && s_tready && (s_tuser == KIND_BAD), m_tvalid && m_tdata[33], "unknown kind not flagged")

    // An error result carries a zero label.
    `LCE_ASSERT_NOW(a_err_label, m_tvalid && m_tdata[33], m_tdata[15:0] == 16'd0, "error result with label")

endmodule

bind label_connectivity_enforcer lce_checker u_lce_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench of the label connectivity enforcer with a built-in label predictor.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lce_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 300;

    // One result as the block reports it.
    typedef struct {
        logic [15:0] lab;
        logic [16:0] cnt;
        logic        st;
    } label_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // pixel_index[15:0], label_in[31:16]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // new_label[15:0], segment_count[32:16], status[33]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    label_connectivity_enforcer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: configuration, label stores and run bookkeeping.
    logic [8:0]  img_w;
    logic [8:0]  img_h;
    logic [16:0] seg_target;
    logic [15:0] in_labels [65536];
    logic [15:0] seg_labels [65536];
    bit          seen [65536];
    int unsigned fill_q [65536];
    logic [16:0] seg_next;
    logic [15:0] adj_label;
    logic [16:0] seg_total;

    label_result_t expected_results[$];

    int errors;
    int items_sent;
    int results_checked;
    int runs_done;
    int cycles;
    int burst_left;
    bit calm;
    bit hold_req;
    int hold_left;
    int rx_mode;
    int rx_mode_left;

    // Clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_mode_left = rx_mode_left - 1;
            if (rx_mode_left <= 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Prints one mismatch and counts it.
    task automatic report(string what, longint got, longint want);
        $display("testbench: mismatch in %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    // Compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report("unexpected result", m_tdata, 0);
            else
            begin
                label_result_t want;
                want = expected_results.pop_front();
                results_checked++;
                if (m_tdata[15:0] !== want.lab)
                    report("new_label", m_tdata[15:0], want.lab);
                if (m_tdata[32:16] !== want.cnt)
                    report("segment_count", m_tdata[32:16], want.cnt);
                if (m_tdata[33] !== want.st)
                    report("status", m_tdata[33], want.st);
            end
        end
    end

    function automatic bit size_valid();
        return img_w >= 1 && img_w <= 256 && img_h >= 1 && img_h <= 256;
    endfunction

    // Raster scan with flood fill; small segments merge into the adjacent label.
    task automatic relabel_image();
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int unsigned lim;
        int unsigned cnt;
        int unsigned head;
        int unsigned p;
        int nx;
        int ny;
        int px;
        int py;
        int ni;
        logic [15:0] cur;
        w = img_w;
        h = img_h;
        lim = ((w * h) / seg_target) >> 2;
        for (int i = 0; i < w * h; i++)
            seen[i] = 1'b0;
        seg_next = '0;
        adj_label = '0;
        idx = 0;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                if (!seen[idx])
                begin
                    cur = seg_next[15:0];
                    seen[idx] = 1'b1;
                    seg_labels[idx] = cur;
                    fill_q[0] = idx;
                    cnt = 1;
                    // Neighbor order left, up, right, down; the last visited one wins.
                    for (int d = 0; d < 4; d++)
                    begin
                        nx = x + ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
                        ny = y + ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
                        if (nx >= 0 && nx < w && ny >= 0 && ny < h)
                        begin
                            ni = ny * w + nx;
                            if (seen[ni])
                                adj_label = seg_labels[ni];
                        end
                    end
                    for (head = 0; head < cnt; head++)
                    begin
                        p = fill_q[head];
                        px = p % w;
                        py = p / w;
                        for (int d = 0; d < 4; d++)
                        begin
                            nx = px + ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
                            ny = py + ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
                            if (nx >= 0 && nx < w && ny >= 0 && ny < h)
                            begin
                                ni = ny * w + nx;
                                if (!seen[ni] && in_labels[ni] == in_labels[idx])
                                begin
                                    seen[ni] = 1'b1;
                                    seg_labels[ni] = cur;
                                    fill_q[cnt] = ni;
                                    cnt++;
                                end
                            end
                        end
                    end
                    if (cnt <= lim)
                    begin
                        for (head = 0; head < cnt; head++)
                            seg_labels[fill_q[head]] = adj_label;
                    end
                    else
                        seg_next = seg_next + 17'd1;
                end
                idx++;
            end
        end
        seg_total = seg_next;
        runs_done++;
    endtask

    // Works out the result of one accepted item and updates the predictor.
    task automatic predict_item(logic [1:0] kind, logic [15:0] idx, logic [15:0] lab);
        label_result_t r;
        bit ok;
        int unsigned pix;
        ok = size_valid();
        pix = ok ? img_w * img_h : 0;
        r.lab = '0;
        r.st = 1'b0;
        if (kind == KIND_WRITE)
        begin
            if (ok && idx < pix)
                in_labels[idx] = lab;
            else
                r.st = 1'b1;
        end
        else if (kind == KIND_RUN)
        begin
            if (ok && seg_target != 0)
                relabel_image();
            else
                r.st = 1'b1;
        end
        else if (kind == KIND_READ)
        begin
            if (ok && idx < pix)
                r.lab = seg_labels[idx];
            else
                r.st = 1'b1;
        end
        else
            r.st = 1'b1;
        r.cnt = seg_total;
        expected_results = {expected_results, r};
    endtask

    // Sends one item in bursts with random gaps; entered and left at a falling edge.
    task automatic send_item(logic [1:0] kind, int unsigned idx, int unsigned lab);
        int gap;
        if (burst_left <= 0)
        begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {lab[15:0], idx[15:0]};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(kind, idx[15:0], lab[15:0]);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Writes one register once every expected result has come back.
    task automatic write_reg(cfg_idx_t r, int v);
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (8) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v[16:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (r)
            CFG_WIDTH:  img_w = v[8:0];
            CFG_HEIGHT: img_h = v[8:0];
            default:    seg_target = v[16:0];
        endcase
    endtask

    task automatic set_geometry(int w, int h, int t);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_TARGET, t);
    endtask

    // Loads a whole map of random labels from a small alphabet, sometimes full range.
    task automatic load_random_map(int alphabet);
        for (int p = 0; p < img_w * img_h; p++)
            send_item(KIND_WRITE, p, ($urandom_range(0, 9) == 0) ? $urandom
                                                               : $urandom_range(0, alphabet));
    endtask

    // Default geometry: writes at both ends of the index range, unknown kind.
    task automatic test_reset_defaults();
        send_item(KIND_WRITE, 16'hFFFF, 16'hFFFF);
        send_item(KIND_WRITE, 16'h0000, 16'h0000);
        send_item(KIND_BAD, 16'hFFFF, 16'hFFFF);
    endtask

    // A 4x4 map with segments below and above the small-segment limit.
    task automatic test_small_map();
        logic [15:0] pattern [16] = '{1, 1, 2, 2, 1, 1, 2, 2, 3, 3, 3, 3, 3, 3, 3, 0};
        set_geometry(4, 4, 1);
        foreach (pattern[i])
            send_item(KIND_WRITE, i, pattern[i]);
        send_item(KIND_RUN, 0, 0);
        for (int i = 0; i < 16; i++)
            send_item(KIND_READ, i, 0);
        send_item(KIND_READ, 16, 0);
        send_item(KIND_WRITE, 16'hFFFF, 16'h5A5A);
    endtask

    // Invalid sizes, zero and largest targets, single-row and single-column maps.
    task automatic test_config_extremes();
        write_reg(CFG_WIDTH, 0);
        send_item(KIND_WRITE, 0, 1);
        send_item(KIND_RUN, 0, 0);
        send_item(KIND_READ, 0, 0);
        write_reg(CFG_WIDTH, 9'h1FF);
        send_item(KIND_RUN, 0, 0);
        set_geometry(4, 0, 1);
        send_item(KIND_READ, 1, 0);
        write_reg(CFG_HEIGHT, 257);
        send_item(KIND_WRITE, 1, 7);
        set_geometry(4, 4, 0);
        send_item(KIND_RUN, 0, 0);
        write_reg(CFG_TARGET, 17'h1FFFF);
        send_item(KIND_RUN, 0, 0);
        send_item(KIND_READ, 5, 0);
        set_geometry(256, 1, 65536);
        load_random_map(3);
        send_item(KIND_RUN, 0, 0);
        send_item(KIND_READ, 255, 0);
        set_geometry(1, 256, 16);
        load_random_map(1);
        send_item(KIND_RUN, 0, 0);
        send_item(KIND_READ, 255, 0);
        send_item(KIND_READ, 256, 0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering items.
    task automatic test_backpressure();
        set_geometry(8, 8, 2);
        hold_req = 1'b1;
        calm = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(KIND_WRITE, i % 64, $urandom);
        calm = 1'b0;
    endtask

    // Random maps, mostly of small sizes: load, run, read back, with noise mixed in.
    task automatic test_random();
        int start;
        int w;
        int h;
        int pix;
        int sel;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            calm = ($urandom_range(0, 3) == 0);
            if (sel == 0)
            begin
                w = 256;
                h = $urandom_range(1, 2);
            end
            else if (sel == 1)
            begin
                w = $urandom_range(1, 2);
                h = 256;
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 12);
            end
            pix = w * h;
            set_geometry(w, h, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17'h1FFFF)
                                                           : $urandom_range(1, 6));
            if ($urandom_range(0, 9) == 0)
            begin
                // Broken setting: every item answers with an error.
                write_reg(CFG_WIDTH, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511));
                send_item(KIND_WRITE, $urandom, $urandom);
                send_item(KIND_RUN, $urandom, $urandom);
                send_item(KIND_READ, $urandom, $urandom);
                write_reg(CFG_WIDTH, w);
            end
            load_random_map($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                send_item(KIND_BAD, $urandom, $urandom);
            if ($urandom_range(0, 2) == 0)
                send_item(KIND_WRITE, $urandom_range(pix, 65535), $urandom);
            if ($urandom_range(0, 11) != 0)
            begin
                send_item(KIND_RUN, $urandom, $urandom);
                for (int i = 0; i < ((pix < 20) ? pix : 20); i++)
                    send_item(KIND_READ, $urandom_range(0, pix - 1), $urandom);
                if ($urandom_range(0, 2) == 0)
                    send_item(KIND_READ, $urandom_range(pix, 65535), $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_WRITE;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        img_w = DIM_RESET;
        img_h = DIM_RESET;
        seg_target = TGT_RESET;
        seg_next = '0;
        adj_label = '0;
        seg_total = '0;
        errors = 0;
        items_sent = 0;
        results_checked = 0;
        runs_done = 0;
        cycles = 0;
        burst_left = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_small_map();
        test_config_extremes();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(negedge clk);
        $display("testbench: %0d transactions sent, %0d results checked, %0d relabeling runs",
                 items_sent, results_checked, runs_done);
        $display("testbench: covered invalid sizes, zero target, out-of-range indexes, stalls");
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
